### rtl/sae_pkg.sv
// Shared types and constants for the static arithmetic encoder.
// Holds the opcode and controller state enums and the table and result structs.
// No dependencies.
package sae_pkg;

  localparam int BOUND_W  = 16;
  localparam int SYMBOL_W = 8;
  localparam int PEND_W   = 16;
  localparam int RES_CNT_W = 5;

  localparam logic [PEND_W-1:0]    PENDING_MAX = 16'hFFFF;
  localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 5'd16;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_ENCODE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIVIDE,
    ST_RENORM
  } state_e;

  typedef struct packed {
    logic [BOUND_W-1:0] lb;
    logic [BOUND_W-1:0] hb;
  } table_entry_t;

  typedef struct packed {
    logic              code_bit;
    logic [PEND_W-1:0] pending;
    logic              last;
  } out_item_t;

endpackage

### rtl/sae_div.sv
// Restoring divider producing one quotient bit per cycle.
// Keeps only the low QUOTIENT_W bits of the quotient. Depends on sae_pkg.
module sae_div #(
  parameter int DIVIDEND_W = 33,
  parameter int QUOTIENT_W = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DIVIDEND_W-1:0]        dividend_i,
  input  logic [sae_pkg::BOUND_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [QUOTIENT_W-1:0]        quotient_o
);
  import sae_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [BOUND_W-1:0]    rem_q, rem_d;
  logic [QUOTIENT_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [BOUND_W:0] rem_sh;
  logic [BOUND_W:0] rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, dvd_q[DIVIDEND_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor_i};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so 16 bits hold it.
      rem_d = ge ? rem_sub[BOUND_W-1:0] : rem_sh[BOUND_W-1:0];
      quo_d = {quo_q[QUOTIENT_W-2:0], ge};
      dvd_d = {dvd_q[DIVIDEND_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/static_arithmetic_encoder_top.sv
// Top level of the static-model arithmetic encoder.
// Holds the frequency table memory, the interval registers and the controller;
// depends on sae_pkg and sae_div.

// A load transaction writes one table entry; the block is ready again in the next
// cycle. An encode transaction reads the table entry, forms the two products, runs
// the two restoring dividers side by side, which give one quotient bit each per cycle,
// then performs one shift per renormalisation step and releases the last result.
// Each renormalisation step that yields a result also waits while the output
// register is stalled. Table contents are undefined until loaded.
module static_arithmetic_encoder_top #(
  parameter int CODE_BITS     = 16,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [sae_pkg::SYMBOL_W-1:0]  symbol_i,
  input  logic [sae_pkg::BOUND_W-1:0]   low_bound_i,
  input  logic [sae_pkg::BOUND_W-1:0]   high_bound_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          code_bit_o,
  output logic [sae_pkg::PEND_W-1:0]    pending_count_o,
  output logic                          last_of_run_o
);
  import sae_pkg::*;

  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int RANGE_W = CODE_BITS + 1;
  localparam int DW = RANGE_W + BOUND_W;
  localparam logic [SYMBOL_W:0]   ALPHA_LIM = (SYMBOL_W + 1)'(ALPHABET_SIZE);
  localparam logic [SYMBOL_W-1:0] LAST_SYM  = SYMBOL_W'(ALPHABET_SIZE - 1);
  localparam logic [CODE_BITS-1:0] TOP_BIT    = {1'b1, {(CODE_BITS-1){1'b0}}};
  localparam logic [CODE_BITS-1:0] SECOND_BIT = {2'b01, {(CODE_BITS-2){1'b0}}};

  // Frequency table memory.
  table_entry_t mem_q [ALPHABET_SIZE];
  table_entry_t rd_q;

  state_e state_q, state_d;

  logic [CODE_BITS-1:0] low_q, low_d;
  logic [CODE_BITS-1:0] high_q, high_d;
  logic [PEND_W-1:0]    pend_q, pend_d;
  logic [BOUND_W-1:0]   total_q, total_d;
  logic [RES_CNT_W-1:0] n_q, n_d;
  logic                 hold_valid_q, hold_valid_d;
  out_item_t            hold_q, hold_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic           in_acc;
  logic           sym_ok;
  logic [AW-1:0]  idx;
  logic           enc_go;
  logic           load_go;
  logic           out_free;
  logic           top_eq;
  logic           underflow;
  logic           can_match;
  logic           div_start;
  logic           up_done;
  logic           dn_done;
  logic [CODE_BITS-1:0] up_quo;
  logic [CODE_BITS-1:0] dn_quo;
  logic [RANGE_W-1:0]   range_w;
  logic [DW-1:0]        prod_up;
  logic [DW-1:0]        prod_dn;
  logic [CODE_BITS-1:0] low_uf;
  logic [CODE_BITS-1:0] high_uf;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sym_ok     = {1'b0, symbol_i} < ALPHA_LIM;
  assign idx        = symbol_i[AW-1:0];
  assign load_go    = in_acc && (opcode_i == OP_LOAD) && sym_ok;
  assign enc_go     = in_acc && (opcode_i == OP_ENCODE) && sym_ok && (total_q != '0);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Underflow is only considered once the top bits differ.
  assign top_eq    = (low_q[CODE_BITS-1] == high_q[CODE_BITS-1]);
  assign underflow = !top_eq && low_q[CODE_BITS-2] && !high_q[CODE_BITS-2];
  assign can_match = top_eq && (n_q < MAX_RESULTS);

  assign range_w = {1'b0, high_q - low_q} + RANGE_W'(1);
  assign prod_up = DW'(range_w) * DW'(rd_q.hb);
  assign prod_dn = DW'(range_w) * DW'(rd_q.lb);

  assign low_uf  = low_q & ~(TOP_BIT | SECOND_BIT);
  assign high_uf = high_q | SECOND_BIT;

  always_ff @(posedge clk_i) begin
    if (load_go) begin
      mem_q[idx] <= '{lb: low_bound_i, hb: high_bound_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc_go) begin
      rd_q <= mem_q[idx];
    end
  end

  sae_div #(
    .DIVIDEND_W (DW),
    .QUOTIENT_W (CODE_BITS)
  ) u_div_up (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_up),
    .divisor_i  (total_q),
    .done_o     (up_done),
    .quotient_o (up_quo)
  );

  sae_div #(
    .DIVIDEND_W (DW),
    .QUOTIENT_W (CODE_BITS)
  ) u_div_dn (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_dn),
    .divisor_i  (total_q),
    .done_o     (dn_done),
    .quotient_o (dn_quo)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (enc_go) state_d = ST_READ;
      end
      ST_READ: state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (up_done && dn_done) state_d = ST_RENORM;
      end
      ST_RENORM: begin
        if (!can_match && !underflow && (!hold_valid_q || out_free)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs. A decided result waits in the hold register until
  // the next step shows whether it is the last one of the transaction.
  always_comb begin
    low_d        = low_q;
    high_d       = high_q;
    pend_d       = pend_q;
    total_d      = total_q;
    n_d          = n_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    div_start    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (load_go && (symbol_i == LAST_SYM)) total_d = high_bound_i;
      end
      ST_READ: div_start = 1'b1;
      ST_DIVIDE: begin
        if (up_done && dn_done) begin
          high_d = low_q + up_quo - CODE_BITS'(1);
          low_d  = low_q + dn_quo;
          n_d    = '0;
        end
      end
      ST_RENORM: begin
        if (can_match) begin
          if (!hold_valid_q || out_free) begin
            if (hold_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = hold_q;
            end
            hold_valid_d    = 1'b1;
            hold_d.code_bit = high_q[CODE_BITS-1];
            hold_d.pending  = pend_q;
            hold_d.last     = 1'b0;
            pend_d          = '0;
            n_d             = n_q + RES_CNT_W'(1);
            low_d           = {low_q[CODE_BITS-2:0], 1'b0};
            high_d          = {high_q[CODE_BITS-2:0], 1'b1};
          end
        end else if (underflow) begin
          if (pend_q != PENDING_MAX) pend_d = pend_q + PEND_W'(1);
          low_d  = {low_uf[CODE_BITS-2:0], 1'b0};
          high_d = {high_uf[CODE_BITS-2:0], 1'b1};
        end else if (hold_valid_q && out_free) begin
          out_valid_d  = 1'b1;
          out_d        = hold_q;
          out_d.last   = 1'b1;
          hold_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      low_q        <= '0;
      high_q       <= '1;
      pend_q       <= '0;
      total_q      <= '0;
      n_q          <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      low_q        <= low_d;
      high_q       <= high_d;
      pend_q       <= pend_d;
      total_q      <= total_d;
      n_q          <= n_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign code_bit_o      = out_q.code_bit;
  assign pending_count_o = out_q.pending;
  assign last_of_run_o   = out_q.last;

endmodule

### rtl/sae_checker.sv
// Port-level assertions for the static arithmetic encoder.
// Bound to static_arithmetic_encoder_top; depends on sae_pkg.
module sae_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       opcode_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       code_bit_o,
  input logic [sae_pkg::PEND_W-1:0] pending_count_o,
  input logic                       last_of_run_o
);
  import sae_pkg::*;

  // A stalled result stays offered.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(code_bit_o) && $stable(pending_count_o)
      && $stable(last_of_run_o))
    else $error("result payload changed while stalled");

  // A load transaction leaves the block ready in the next cycle.
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == OP_LOAD) |=> !in_stall_o)
    else $error("load transaction did not complete in one cycle");

  // While idle with no result waiting, no result appears in the next cycle.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_stall_o |=> !out_valid_o)
    else $error("result appeared without an encode in progress");

  // A result that is not the last of its run is offered while the encode continues.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> in_stall_o)
    else $error("run ended without a final result");

endmodule

bind static_arithmetic_encoder_top sae_checker u_sae_checker (.*);

### tb/tb_static_arithmetic_encoder_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for static_arithmetic_encoder_top: table loads and symbol encodes
// are driven over a valid/stall channel and each decided bit is scored against a predictor.
// Depends on sae_pkg and the encoder RTL only.
module tb_static_arithmetic_encoder_top;
  import sae_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int          HOLD_CYCLES = 600;
  localparam int          DRAIN_CYCLES = 100;
  localparam int          PEND_STEPS = 4;

  typedef struct {
    opcode_e           op;
    logic [7:0]        sym;
    logic [15:0]       lb;
    logic [15:0]       hb;
    bit                typed;
    int                n_typed;
    logic              typed_bit;
    logic [15:0]       typed_pend;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic opcode_i = 1'b0;
  logic [SYMBOL_W-1:0] symbol_i = '0;
  logic [BOUND_W-1:0] low_bound_i = '0;
  logic [BOUND_W-1:0] high_bound_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic code_bit_o;
  logic [PEND_W-1:0] pending_count_o;
  logic last_of_run_o;

  always #2 clk_i = ~clk_i;

  static_arithmetic_encoder_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .symbol_i       (symbol_i),
    .low_bound_i    (low_bound_i),
    .high_bound_i   (high_bound_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_bit_o     (code_bit_o),
    .pending_count_o(pending_count_o),
    .last_of_run_o  (last_of_run_o)
  );

  // Predictor state: frequency table, coding interval and the pending count.
  logic [15:0] tab_lb [256];
  logic [15:0] tab_hb [256];
  logic [15:0] iv_low = 16'h0000;
  logic [15:0] iv_high = 16'hFFFF;
  logic [15:0] pend_bits = 16'h0000;

  out_item_t step_results [$];
  out_item_t decided_bits_q [$];
  bit written [256];
  logic [7:0] written_syms [$];
  int send_idle_pct = 29;
  int recv_stall_pct = 74;
  int idle_phase = 0;
  int mismatch_cnt = 0;

  // Works out the decided bits that one transaction causes and leaves them in step_results.
  task automatic narrow_and_renorm(input row_t r);
    logic [15:0] diff;
    logic [15:0] total;
    logic [15:0] old_low;
    logic [63:0] span;
    logic [63:0] up;
    logic [63:0] dn;
    out_item_t res;
    int n;
    step_results.delete();
    if (r.op == OP_LOAD) begin
      tab_lb[r.sym] = r.lb;
      tab_hb[r.sym] = r.hb;
      return;
    end
    total = tab_hb[255];
    if (total == 16'h0000) return;
    diff = iv_high - iv_low;
    span = 64'(diff) + 64'd1;
    up = span * 64'(tab_hb[r.sym]) / 64'(total);
    dn = span * 64'(tab_lb[r.sym]) / 64'(total);
    old_low = iv_low;
    iv_high = 16'(64'(old_low) + up - 64'd1);
    iv_low = 16'(64'(old_low) + dn);
    n = 0;
    forever begin
      if (iv_high[15] == iv_low[15]) begin
        if (n >= MAX_RESULTS) break;
        res.code_bit = iv_high[15];
        res.pending = pend_bits;
        res.last = 1'b0;
        step_results.push_back(res);
        pend_bits = 16'h0000;
        n++;
      end else if (iv_low[14] && !iv_high[14]) begin
        if (pend_bits != PENDING_MAX) pend_bits = pend_bits + 16'd1;
        iv_low[15:14] = 2'b00;
        iv_high[14] = 1'b1;
      end else begin
        break;
      end
      iv_low = {iv_low[14:0], 1'b0};
      iv_high = {iv_high[14:0], 1'b1};
    end
    if (n > 0) step_results[n-1].last = 1'b1;
  endtask

  // Offers one transaction, waits for it to be taken and books the expected results.
  task automatic send_item(input row_t r);
    out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= r.op;
    symbol_i <= r.sym;
    low_bound_i <= r.lb;
    high_bound_i <= r.hb;
    do @(posedge clk_i); while (in_stall_o);
    narrow_and_renorm(r);
    if (r.op == OP_LOAD && !written[r.sym]) begin
      written[r.sym] = 1'b1;
      written_syms.push_back(r.sym);
    end
    if (r.typed) begin
      for (int k = 0; k < r.n_typed; k++) begin
        res.code_bit = r.typed_bit;
        res.pending = r.typed_pend;
        res.last = (k == r.n_typed - 1);
        decided_bits_q.push_back(res);
      end
    end else begin
      foreach (step_results[k]) decided_bits_q.push_back(step_results[k]);
    end
  endtask

  // Loads a symbol whose share makes low equal high, so the interval ends up full again.
  task automatic restore_full_interval(input logic [7:0] sym);
    row_t r;
    logic [15:0] diff;
    logic [63:0] span;
    diff = iv_high - iv_low;
    span = 64'(diff) + 64'd1;
    r = '{OP_LOAD, sym, 16'h0000, 16'h0000, 1'b0, 0, 1'b0, 16'h0000};
    r.hb = 16'((64'd65535 + span - 64'd1) / span);
    send_item(r);
    r.op = OP_ENCODE;
    send_item(r);
  endtask

  initial begin : receiver
    int hold_left;
    bit hold_done;
    out_item_t exp_res;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (decided_bits_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: bit %0b pending %0d last %0b",
                     code_bit_o, pending_count_o, last_of_run_o);
        end else begin
          exp_res = decided_bits_q.pop_front();
          if (code_bit_o !== exp_res.code_bit || pending_count_o !== exp_res.pending ||
              last_of_run_o !== exp_res.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("result mismatch: expected bit %0b pending %0d last %0b, got %0b %0d %0b",
                       exp_res.code_bit, exp_res.pending, exp_res.last,
                       code_bit_o, pending_count_o, last_of_run_o);
          end
        end
      end
      // A single long hold-off lets the encoder back up until it stalls its input.
      if (hold_left > 0) begin
        hold_left--;
      end else if (idle_phase == 2 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    row_t dir_tab [25];
    row_t r;
    logic [15:0] total;
    dir_tab = '{
      // Zero total: the encode leaves everything as it is.
      '{OP_LOAD,   8'd255, 16'h0000, 16'h0000, 1'b1, 0, 1'b0, 16'h0000},
      '{OP_LOAD,   8'd0,   16'h0000, 16'h0000, 1'b1, 0, 1'b0, 16'h0000},
      '{OP_ENCODE, 8'd0,   16'h0000, 16'h0000, 1'b1, 0, 1'b0, 16'h0000},
      // Two halves from the reset interval: one decided bit each.
      '{OP_LOAD,   8'd255, 16'h0001, 16'h0002, 1'b1, 0, 1'b0, 16'h0000},
      '{OP_LOAD,   8'd0,   16'h0000, 16'h0001, 1'b1, 0, 1'b0, 16'h0000},
      '{OP_ENCODE, 8'd0,   16'h0000, 16'h0000, 1'b1, 1, 1'b0, 16'h0000},
      '{OP_ENCODE, 8'd255, 16'h0000, 16'h0000, 1'b1, 1, 1'b1, 16'h0000},
      // Largest total; the narrowest share yields the full run of results.
      '{OP_LOAD,   8'd255, 16'hFFFE, 16'hFFFF, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_LOAD,   8'd7,   16'h0000, 16'h0001, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_ENCODE, 8'd7,   16'h0000, 16'h0000, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_LOAD,   8'd1,   16'h0000, 16'hFFFF, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_ENCODE, 8'd1,   16'h0000, 16'h0000, 1'b0, 0, 1'b0, 16'h0000},
      // A share straddling the midpoint builds up pending bits.
      '{OP_LOAD,   8'd2,   16'h7FFF, 16'h8001, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_ENCODE, 8'd2,   16'h0000, 16'h0000, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_ENCODE, 8'd7,   16'h0000, 16'h0000, 1'b0, 0, 1'b0, 16'h0000},
      // Inconsistent bounds are taken as given and wrap.
      '{OP_LOAD,   8'd3,   16'h8000, 16'h8000, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_ENCODE, 8'd3,   16'h0000, 16'h0000, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_LOAD,   8'd4,   16'hFFFF, 16'h0000, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_ENCODE, 8'd4,   16'h0000, 16'h0000, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_LOAD,   8'd5,   16'hFFFF, 16'hFFFF, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_ENCODE, 8'd5,   16'h0000, 16'h0000, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_LOAD,   8'd255, 16'h0000, 16'hFFFF, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_ENCODE, 8'd255, 16'h0000, 16'h0000, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_LOAD,   8'd8,   16'hAAAA, 16'h5555, 1'b0, 0, 1'b0, 16'h0000},
      '{OP_ENCODE, 8'd8,   16'h0000, 16'h0000, 1'b0, 0, 1'b0, 16'h0000}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i]);

    for (int p = 0; p < 3; p++) begin
      idle_phase = p;
      send_idle_pct = (p == 0) ? 29 : (p == 1) ? 74 : 0;
      recv_stall_pct = (p == 0) ? 74 : (p == 1) ? 29 : 0;
      repeat (30) begin
        r = '{OP_ENCODE, 8'd0, 16'h0000, 16'h0000, 1'b0, 0, 1'b0, 16'h0000};
        if ($urandom_range(99) < 30) begin
          r.op = OP_LOAD;
          r.sym = 8'($urandom_range(255));
          if (r.sym == 8'd255) begin
            // Now and then the total drops to zero.
            r.hb = ($urandom_range(19) == 0) ? 16'h0000 : 16'($urandom_range(65535, 1));
            r.lb = 16'($urandom_range(r.hb, 0));
          end else if ($urandom_range(99) < 70) begin
            total = tab_hb[255];
            r.lb = 16'($urandom_range(total, 0));
            r.hb = 16'($urandom_range(total, r.lb));
          end else begin
            r.lb = 16'($urandom);
            r.hb = 16'($urandom);
          end
        end else begin
          r.sym = written_syms[$urandom_range(written_syms.size() - 1)];
        end
        send_item(r);
      end
    end

    // Build up a long run of pending bits from the full interval, then release it.
    r = '{OP_LOAD, 8'd255, 16'h0000, 16'hFFFF, 1'b0, 0, 1'b0, 16'h0000};
    send_item(r);
    restore_full_interval(8'd9);
    r = '{OP_LOAD, 8'd10, 16'h7FFF, 16'h8001, 1'b0, 0, 1'b0, 16'h0000};
    send_item(r);
    r.op = OP_ENCODE;
    repeat (PEND_STEPS) send_item(r);
    restore_full_interval(8'd9);

    in_valid_i <= 1'b0;
    while (decided_bits_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && decided_bits_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
